// ===== hw/rtl/multiindex_graded_rank_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the graded multiindex rank core
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MULTIINDEX_GRADED_RANK_CORE_MACROS_SVH
`define MULTIINDEX_GRADED_RANK_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define MGR_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Implication with a fixed delay of cycles between cause and effect.
`define MGR_ASSERT_DELAY(label, clk, rst, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error("delayed check failed");

`endif

// ===== hw/rtl/mgr_pkg.sv =====
// ----------------------------------------------------------------------------
// Graded multiindex rank package
// Sizes, status codes, shared structs and the binomial coefficient table.
// ----------------------------------------------------------------------------
package mgr_pkg;

  // Problem sizes.
  localparam int MAX_DIM   = 8;
  localparam int MAX_TOTAL = 63;
  localparam int NUM_LANES = MAX_DIM;
  localparam int ROM_ROWS  = MAX_TOTAL + MAX_DIM;
  localparam int ROM_COLS  = MAX_DIM + 1;
  localparam int ROW_W     = $clog2(ROM_ROWS);
  localparam int COL_W     = $clog2(ROM_COLS);
  localparam int COMP_W    = 6;
  localparam int MAG_W     = COMP_W - 1;
  localparam int DIM_W     = 4;
  localparam int SUM_W     = 8;
  localparam int COEF_W    = 34;
  localparam int POS_W     = 35;

  // Result status codes.
  localparam logic [1:0] STATUS_OK  = 2'd0;
  localparam logic [1:0] STATUS_NEG = 2'd1;
  localparam logic [1:0] STATUS_BIG = 2'd2;

  typedef logic [COEF_W-1:0] coef_t;
  typedef coef_t [ROM_COLS-1:0] rom_row_t;
  typedef rom_row_t [ROM_ROWS-1:0] rom_t;

  // Table lookup request handed to one lane.
  typedef struct packed {
    logic             active;
    logic [ROW_W-1:0] n;
    logic [COL_W-1:0] k;
  } lane_req_t;

  // Control that travels with an item down the pipeline.
  typedef struct packed {
    logic       valid;
    logic [1:0] status;
  } ctl_t;

  // Pascal triangle, evaluated once at elaboration.
  function automatic rom_t build_rom();
    rom_t rom;
    rom = '0;
    for (int n = 0; n < ROM_ROWS; n++) begin
      rom[n][0] = coef_t'(1);
      for (int k = 1; k < ROM_COLS; k++) begin
        if (k > n) begin
          rom[n][k] = '0;
        end else if (k == n) begin
          rom[n][k] = coef_t'(1);
        end else begin
          rom[n][k] = rom[n-1][k-1] + rom[n-1][k];
        end
      end
    end
    return rom;
  endfunction

endpackage

// ===== hw/rtl/mgr_lane.sv =====
// ----------------------------------------------------------------------------
// Graded rank lane
// Looks up one binomial term C(n,k) with a registered table read.
// ----------------------------------------------------------------------------
module mgr_lane (
  input  logic              clk,
  input  mgr_pkg::lane_req_t req,
  output mgr_pkg::coef_t    term
);
  import mgr_pkg::*;

  localparam rom_t BINOM_ROM = build_rom();

  // Registered table read; idle lanes contribute zero.
  always_ff @(posedge clk) begin
    if (req.active) begin
      term <= BINOM_ROM[req.n][req.k];
    end else begin
      term <= '0;
    end
  end

endmodule

// ===== hw/rtl/mgr_merge.sv =====
// ----------------------------------------------------------------------------
// Graded rank merge
// Adds the lane terms in a two-level registered tree and drives the result.
// ----------------------------------------------------------------------------
module mgr_merge (
  input  logic                                   clk,
  input  logic                                   rst,
  input  mgr_pkg::coef_t [mgr_pkg::NUM_LANES-1:0] terms,
  input  mgr_pkg::ctl_t                          ctl,
  output logic                                   done,
  output logic signed [mgr_pkg::POS_W-1:0]       position,
  output logic [1:0]                             status
);
  import mgr_pkg::*;

  localparam int PAIRS = (NUM_LANES + 1) / 2;

  logic [PAIRS-1:0][POS_W-1:0] pair_sum;
  logic [PAIRS-1:0][POS_W-1:0] pair_sum_next;
  ctl_t                        pair_ctl;
  logic [POS_W-1:0]            total_next;

  // First level: add neighboring lanes.
  always_comb begin
    for (int p = 0; p < PAIRS; p++) begin
      pair_sum_next[p] = POS_W'(terms[2*p]);
      if (2*p + 1 < NUM_LANES) begin
        pair_sum_next[p] = pair_sum_next[p] + POS_W'(terms[2*p+1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    pair_sum <= pair_sum_next;
    if (rst) begin
      pair_ctl <= '0;
    end else begin
      pair_ctl <= ctl;
    end
  end

  // Second level: add the pair sums.
  always_comb begin
    total_next = '0;
    for (int p = 0; p < PAIRS; p++) begin
      total_next = total_next + pair_sum[p];
    end
  end

  // Output register; failed items report all ones.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pair_ctl.valid;
    end
    status <= pair_ctl.status;
    if (pair_ctl.status == STATUS_OK) begin
      position <= total_next;
    end else begin
      position <= '1;
    end
  end

endmodule

// ===== hw/rtl/multiindex_graded_rank_core.sv =====
// ----------------------------------------------------------------------------
// Graded multiindex rank core
// Pipeline: input, lane request, table read, pair sum and output registers.
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// The rate is set by eight lanes each reading its own binomial table port.
// Reset clears all pipeline valid bits and sets dimension to eight.
// ----------------------------------------------------------------------------
module multiindex_graded_rank_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mgr_pkg::DIM_W-1:0]           cfg_wdata,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [mgr_pkg::COMP_W-1:0]   component_0,
  input  logic signed [mgr_pkg::COMP_W-1:0]   component_1,
  input  logic signed [mgr_pkg::COMP_W-1:0]   component_2,
  input  logic signed [mgr_pkg::COMP_W-1:0]   component_3,
  input  logic signed [mgr_pkg::COMP_W-1:0]   component_4,
  input  logic signed [mgr_pkg::COMP_W-1:0]   component_5,
  input  logic signed [mgr_pkg::COMP_W-1:0]   component_6,
  input  logic signed [mgr_pkg::COMP_W-1:0]   component_7,
  output logic                                done,
  output logic signed [mgr_pkg::POS_W-1:0]    position,
  output logic [1:0]                          status
);
  import mgr_pkg::*;

  logic [DIM_W-1:0]                   dimension;
  logic [DIM_W-1:0]                   dim_sat;
  logic [NUM_LANES-1:0][COMP_W-1:0]   comp_in;
  logic [NUM_LANES-1:0][MAG_W-1:0]    mag_next;
  logic                               neg_next;
  logic                               accept;

  logic                               a_valid;
  logic                               a_neg;
  logic [DIM_W-1:0]                   a_dim;
  logic [NUM_LANES-1:0][MAG_W-1:0]    a_mag;

  logic [NUM_LANES:0][SUM_W-1:0]      suffix;
  logic [SUM_W-1:0]                   n_full;
  logic                               big;
  lane_req_t [NUM_LANES-1:0]          req_next;
  lane_req_t [NUM_LANES-1:0]          b_req;
  ctl_t                               b_ctl_next;
  ctl_t                               b_ctl;
  ctl_t                               l_ctl;
  coef_t [NUM_LANES-1:0]              terms;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Dimension register.
  always_ff @(posedge clk) begin
    if (rst) begin
      dimension <= DIM_W'(MAX_DIM);
    end else if (cfg_we) begin
      dimension <= cfg_wdata;
    end
  end

  assign comp_in[0] = component_0;
  assign comp_in[1] = component_1;
  assign comp_in[2] = component_2;
  assign comp_in[3] = component_3;
  assign comp_in[4] = component_4;
  assign comp_in[5] = component_5;
  assign comp_in[6] = component_6;
  assign comp_in[7] = component_7;

  // Saturate the dimension, drop unused components and flag negatives.
  always_comb begin
    dim_sat  = (dimension > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : dimension;
    neg_next = 1'b0;
    for (int j = 0; j < NUM_LANES; j++) begin
      if (DIM_W'(j) < dim_sat) begin
        neg_next    = neg_next | comp_in[j][COMP_W-1];
        mag_next[j] = comp_in[j][MAG_W-1:0];
      end else begin
        mag_next[j] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= accept;
    end
    a_neg <= neg_next;
    a_dim <= dim_sat;
    a_mag <= mag_next;
  end

  // Remaining totals per component and the table address for each lane.
  always_comb begin
    suffix[NUM_LANES] = '0;
    for (int j = NUM_LANES - 1; j >= 0; j--) begin
      suffix[j] = suffix[j+1] + SUM_W'(a_mag[j]);
    end
    big = suffix[0] > SUM_W'(MAX_TOTAL);
    n_full = '0;
    for (int j = 0; j < NUM_LANES; j++) begin
      n_full = suffix[j] + SUM_W'(a_dim) - SUM_W'(j) - SUM_W'(1);
      req_next[j].active = !a_neg && !big && (DIM_W'(j) < a_dim);
      req_next[j].n      = req_next[j].active ? n_full[ROW_W-1:0] : '0;
      req_next[j].k      = COL_W'(a_dim - DIM_W'(j));
    end
    b_ctl_next.valid = a_valid;
    if (a_neg) begin
      b_ctl_next.status = STATUS_NEG;
    end else if (big) begin
      b_ctl_next.status = STATUS_BIG;
    end else begin
      b_ctl_next.status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    b_req <= req_next;
    if (rst) begin
      b_ctl <= '0;
      l_ctl <= '0;
    end else begin
      b_ctl <= b_ctl_next;
      l_ctl <= b_ctl;
    end
  end

  // One table lane per component.
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    mgr_lane u_lane (
      .clk  (clk),
      .req  (b_req[g]),
      .term (terms[g])
    );
  end

  // Merge the lane terms into the rank.
  mgr_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .terms    (terms),
    .ctl      (l_ctl),
    .done     (done),
    .position (position),
    .status   (status)
  );

endmodule

// ===== hw/rtl/mgr_checker.sv =====
// ----------------------------------------------------------------------------
// Graded rank port checker
// Watches the core's ports for result timing and result encoding.
// ----------------------------------------------------------------------------
`include "multiindex_graded_rank_core_macros.svh"

module mgr_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             start,
  input logic                             busy,
  input logic                             done,
  input logic signed [mgr_pkg::POS_W-1:0] position,
  input logic [1:0]                       status
);
  import mgr_pkg::*;

  // Every accepted item produces its result after the fixed latency.
  `MGR_ASSERT_DELAY(a_accept_done, clk, rst, start && !busy, 5, done)

  // A result strobe always traces back to an accepted item.
  `MGR_ASSERT_SAME(a_done_origin, clk, rst, done, $past(start, 5) && !$past(busy, 5))

  // A failed item reports the all-ones position.
  `MGR_ASSERT_SAME(a_fail_pos, clk, rst, done && (status != STATUS_OK), position == '1)

  // A successful rank is never negative.
  `MGR_ASSERT_SAME(a_ok_pos, clk, rst, done && (status == STATUS_OK), !position[POS_W-1])

endmodule

bind multiindex_graded_rank_core mgr_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .position (position),
  .status   (status)
);

// ===== tb/multiindex_graded_rank_core_test.sv =====
// ----------------------------------------------------------------------------
// Graded multiindex rank core testbench
// Sends multiindices under several dimension settings and checks each rank
// and status against a rank predictor built into the bench.
// ----------------------------------------------------------------------------
module multiindex_graded_rank_core_test;
  import mgr_pkg::*;

  // Result latency as the port checker asserts it, plus some margin.
  localparam int RESULT_LATENCY = 5;
  localparam int SETTLE_CYCLES  = RESULT_LATENCY + 3;
  localparam int CYCLE_LIMIT    = 200000;

  typedef logic [MAX_DIM-1:0][COMP_W-1:0] comp_vec_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [1:0]       status;
  } rank_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_we;
  logic [DIM_W-1:0]          cfg_wdata;
  logic                      start;
  logic                      busy;
  logic signed [COMP_W-1:0]  component_0;
  logic signed [COMP_W-1:0]  component_1;
  logic signed [COMP_W-1:0]  component_2;
  logic signed [COMP_W-1:0]  component_3;
  logic signed [COMP_W-1:0]  component_4;
  logic signed [COMP_W-1:0]  component_5;
  logic signed [COMP_W-1:0]  component_6;
  logic signed [COMP_W-1:0]  component_7;
  logic                      done;
  logic signed [POS_W-1:0]   position;
  logic [1:0]                status;

  // Dimension register as the bench believes it to be.
  logic [DIM_W-1:0] dimension_shadow;
  rank_t            pending_ranks[$];
  int               error_count = 0;
  int               cycle_count = 0;

  multiindex_graded_rank_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .start       (start),
    .busy        (busy),
    .component_0 (component_0),
    .component_1 (component_1),
    .component_2 (component_2),
    .component_3 (component_3),
    .component_4 (component_4),
    .component_5 (component_5),
    .component_6 (component_6),
    .component_7 (component_7),
    .done        (done),
    .position    (position),
    .status      (status)
  );

  // Clock with a period of 20.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Binomial coefficient by the multiplicative formula; exact at these sizes.
  function automatic longint unsigned choose(input int unsigned n, input int unsigned k);
    longint unsigned acc;
    acc = 1;
    if (k > n) begin
      return 0;
    end
    for (int unsigned i = 1; i <= k; i++) begin
      acc = acc * (n - k + i) / i;
    end
    return acc;
  endfunction

  // Expected rank and status of one multiindex under a given dimension.
  function automatic rank_t predict_rank(input comp_vec_t comps,
                                         input logic [DIM_W-1:0] dim_reg);
    rank_t           r;
    int unsigned     used;
    int unsigned     total;
    int unsigned     remain;
    longint unsigned pos;
    used  = (dim_reg > MAX_DIM) ? MAX_DIM : dim_reg;
    total = 0;
    pos   = 0;
    r.position = '1;
    // A negative component in use means no rank, and it wins over size.
    for (int unsigned j = 0; j < used; j++) begin
      if (comps[j][COMP_W-1]) begin
        r.status = STATUS_NEG;
        return r;
      end
      total += comps[j];
    end
    if (total > MAX_TOTAL) begin
      r.status = STATUS_BIG;
      return r;
    end
    remain = total;
    for (int unsigned j = 0; j < used; j++) begin
      pos += choose(remain + used - j - 1, used - j);
      remain -= comps[j];
    end
    r.position = pos[POS_W-1:0];
    r.status   = STATUS_OK;
    return r;
  endfunction

  function automatic comp_vec_t pack_components(input int c0, input int c1, input int c2,
                                                input int c3, input int c4, input int c5,
                                                input int c6, input int c7);
    comp_vec_t v;
    v[0] = COMP_W'(c0);
    v[1] = COMP_W'(c1);
    v[2] = COMP_W'(c2);
    v[3] = COMP_W'(c3);
    v[4] = COMP_W'(c4);
    v[5] = COMP_W'(c5);
    v[6] = COMP_W'(c6);
    v[7] = COMP_W'(c7);
    return v;
  endfunction

  // Random multiindex: mostly valid ones with a random total, some with a
  // negative component slipped in, and some with every bit random.
  function automatic comp_vec_t random_multiindex(input logic [DIM_W-1:0] dim_reg);
    comp_vec_t   v;
    int unsigned used;
    int unsigned budget;
    int unsigned pick;
    int unsigned idx;
    int unsigned val;
    bit          reversed;
    used = (dim_reg > MAX_DIM) ? MAX_DIM : dim_reg;
    for (int j = 0; j < MAX_DIM; j++) begin
      v[j] = COMP_W'($urandom);
    end
    pick = $urandom_range(0, 99);
    if (pick < 90 && used > 0) begin
      budget   = $urandom_range(0, MAX_TOTAL);
      reversed = $urandom_range(0, 1);
      for (int unsigned i = 0; i < used; i++) begin
        idx = reversed ? used - 1 - i : i;
        val = $urandom_range(0, (budget < 31) ? budget : 31);
        v[idx] = COMP_W'(val);
        budget -= val;
      end
      if (pick >= 75) begin
        idx = $urandom_range(0, used - 1);
        v[idx][COMP_W-1] = 1'b1;
      end
    end
    return v;
  endfunction

  // Mismatch report: one line per failure.
  task automatic report_mismatch(input string what, input longint expected_value,
                                 input longint actual_value);
    $display("mismatch at cycle %0d: %s expected %0d got %0d",
             cycle_count, what, expected_value, actual_value);
    error_count++;
  endtask

  // Present one item and hold it until the core takes it.
  task automatic send_item(input comp_vec_t comps);
    component_0 <= comps[0];
    component_1 <= comps[1];
    component_2 <= comps[2];
    component_3 <= comps[3];
    component_4 <= comps[4];
    component_5 <= comps[5];
    component_6 <= comps[6];
    component_7 <= comps[7];
    start       <= 1'b1;
    do @(posedge clk); while (busy);
    pending_ranks.push_back(predict_rank(comps, dimension_shadow));
  endtask

  task automatic idle_cycles(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stop sending and wait for every outstanding rank to come back.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_ranks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Dimension writes happen only with the pipeline empty.
  task automatic set_dimension(input logic [DIM_W-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we           <= 1'b0;
    dimension_shadow  = value;
    @(posedge clk);
  endtask

  // Extreme and special multiindices at the reset dimension of eight.
  task automatic test_directed_extremes();
    send_item(pack_components(0, 0, 0, 0, 0, 0, 0, 0));
    send_item(pack_components(1, 0, 0, 0, 0, 0, 0, 0));
    send_item(pack_components(0, 0, 0, 0, 0, 0, 0, 1));
    send_item(pack_components(0, 0, 0, 0, 0, 0, 0, 31));
    send_item(pack_components(31, 31, 1, 0, 0, 0, 0, 0));
    send_item(pack_components(0, 0, 0, 0, 0, 1, 31, 31));
    send_item(pack_components(31, 31, 2, 0, 0, 0, 0, 0));
    send_item(pack_components(31, 31, 31, 31, 31, 31, 31, 31));
    send_item(pack_components(0, 0, 0, 0, 0, 0, 0, -1));
    send_item(pack_components(-32, -32, -32, -32, -32, -32, -32, -32));
    send_item(pack_components(31, 31, 31, -32, 31, 31, 31, 31));
    send_item(pack_components(7, 8, 7, 8, 7, 8, 7, 8));
  endtask

  // Small, empty and oversized dimension settings.
  task automatic test_dimension_register();
    set_dimension(4'd1);
    send_item(pack_components(31, -1, -32, 5, 0, 0, 0, 0));
    send_item(pack_components(0, 31, 31, 31, 31, 31, 31, 31));
    send_item(pack_components(-1, 0, 0, 0, 0, 0, 0, 0));
    set_dimension(4'd0);
    send_item(pack_components(-32, -32, -32, -32, -32, -32, -32, -32));
    send_item(pack_components(31, 31, 31, 31, 31, 31, 31, 31));
    set_dimension(4'd15);
    send_item(pack_components(1, 2, 3, 4, 5, 6, 7, 8));
    send_item(pack_components(0, 0, 0, 0, 0, 0, 0, -32));
    set_dimension(4'd9);
    send_item(pack_components(0, 0, 0, 0, 0, 0, 31, 31));
    set_dimension(4'd2);
    send_item(pack_components(31, 31, 31, -1, -1, -1, -1, -1));
    send_item(pack_components(31, 32, 0, 0, 0, 0, 0, 0));
  endtask

  // Random multiindices over a series of dimension settings, with random
  // gaps on the sending side and one full pause partway through.
  task automatic test_random_ranks();
    logic [DIM_W-1:0] phase_dims [12];
    phase_dims = '{4'd8, 4'd1, 4'd3, 4'd5, 4'd2, 4'd7, 4'd4, 4'd6,
                   4'd0, 4'd12, 4'd8, 4'd3};
    for (int p = 0; p < 12; p++) begin
      set_dimension(phase_dims[p]);
      for (int i = 0; i < 80; i++) begin
        send_item(random_multiindex(dimension_shadow));
        if (p == 3 && i == 40) begin
          drain_results();
        end else if ($urandom_range(0, 3) == 0) begin
          idle_cycles($urandom_range(1, 13));
        end
      end
    end
  endtask

  // Closing stretch at full rate, with no gaps but the drain for the dimension change.
  task automatic test_back_to_back();
    set_dimension(4'd8);
    for (int i = 0; i < 100; i++) begin
      send_item(random_multiindex(dimension_shadow));
    end
    set_dimension(4'd5);
    for (int i = 0; i < 60; i++) begin
      send_item(random_multiindex(dimension_shadow));
    end
  endtask

  // Result checker and run watchdog.
  always @(posedge clk) begin
    rank_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL multiindex_graded_rank_core");
      $finish;
    end else if (!rst && done) begin
      if (pending_ranks.size() == 0) begin
        report_mismatch("unexpected result, position", -1, position);
      end else begin
        want = pending_ranks.pop_front();
        if (position !== signed'(want.position)) begin
          report_mismatch("position", signed'(want.position), position);
        end
        if (status !== want.status) begin
          report_mismatch("status", want.status, status);
        end
      end
    end
  end

  // Reset, then the tests in turn, then the verdict.
  initial begin
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    start            <= 1'b0;
    component_0      <= '0;
    component_1      <= '0;
    component_2      <= '0;
    component_3      <= '0;
    component_4      <= '0;
    component_5      <= '0;
    component_6      <= '0;
    component_7      <= '0;
    dimension_shadow  = 4'd8;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_extremes();
    test_dimension_register();
    test_random_ranks();
    test_back_to_back();

    drain_results();
    if (pending_ranks.size() != 0) begin
      report_mismatch("results never returned", 0, pending_ranks.size());
    end
    if (error_count == 0) begin
      $display("PASS multiindex_graded_rank_core");
    end else begin
      $display("FAIL multiindex_graded_rank_core");
    end
    $finish;
  end

endmodule
